// ===== rtl/lpbe_pkg.sv =====
`default_nettype none

package lpbe_pkg;

  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned PctWidth     = 7;
  localparam int unsigned ProdWidth    = ChanWidth + PctWidth;
  localparam int unsigned CntWidth     = 6;
  localparam int unsigned SlotsWidth   = 7;

  localparam logic [PctWidth-1:0]   FullPercent  = 7'd100;
  localparam logic [7:0]            DutyOneReset = 8'd60;
  localparam logic [7:0]            DutyZeroReset = 8'd30;
  localparam logic [SlotsWidth-1:0] SlotsReset   = 7'd50;
  localparam logic [SlotsWidth-1:0] MaxGapSlots  = 7'd64;

  // x / 100 == (x * 5243) >> 19 for every x up to 255 * 100
  localparam int unsigned RecipWidth = 13;
  localparam logic [RecipWidth-1:0] RecipMul = 13'd5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipProdWidth = ProdWidth + RecipWidth;

  localparam logic [CntWidth-1:0] PixelLastIdx = 6'(BitsPerPixel - 1);

  typedef enum logic [1:0] {
    REG_DUTY_ONE    = 2'd0,
    REG_DUTY_ZERO   = 2'd1,
    REG_RESET_SLOTS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_LATCH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0]            duty_one;
    logic [7:0]            duty_zero;
    logic [SlotsWidth-1:0] reset_slots;
  } cfg_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic [BitsPerPixel-1:0] word;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/lpbe_ifs.sv =====
`default_nettype none

interface lpbe_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] brightness;

  modport source (output valid, cmd, red, green, blue, brightness, input ready);
  modport sink   (input valid, cmd, red, green, blue, brightness, output ready);
endinterface

interface lpbe_duty_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       last;

  modport source (output valid, duty, last, input ready);
  modport sink   (input valid, duty, last, output ready);
endinterface

interface lpbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpbe_front.sv =====
`default_nettype none

module lpbe_front
  import lpbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  lpbe_pix_if.sink      pix,
  output q_entry_t      q_data,
  output logic          q_valid,
  input  wire logic     q_ready
);

  // stage a: channel * percent
  logic                 a_valid;
  cmd_e                 a_cmd;
  logic [ProdWidth-1:0] a_r, a_g, a_b;
  // stage b: divide by a hundred
  logic                 b_valid;
  q_entry_t             b_entry;

  logic                 a_adv, b_adv;
  logic [PctWidth-1:0]  pct;
  logic [RecipProdWidth-1:0] rq, gq, bq;

  assign b_adv     = !b_valid || q_ready;
  assign a_adv     = !a_valid || b_adv;
  assign pix.ready = a_adv;

  assign pct = (pix.brightness > FullPercent) ? FullPercent : pix.brightness;

  assign rq = RecipProdWidth'(a_r) * RecipProdWidth'(RecipMul);
  assign gq = RecipProdWidth'(a_g) * RecipProdWidth'(RecipMul);
  assign bq = RecipProdWidth'(a_b) * RecipProdWidth'(RecipMul);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= pix.valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && pix.valid) begin
      a_cmd <= cmd_e'(pix.cmd);
      a_r   <= ProdWidth'(pix.red)   * ProdWidth'(pct);
      a_g   <= ProdWidth'(pix.green) * ProdWidth'(pct);
      a_b   <= ProdWidth'(pix.blue)  * ProdWidth'(pct);
    end
    if (b_adv && a_valid) begin
      b_entry.cmd  <= a_cmd;
      b_entry.word <= {gq[RecipShift +: ChanWidth], rq[RecipShift +: ChanWidth],
                       bq[RecipShift +: ChanWidth]};
    end
  end

  assign q_valid = b_valid;
  assign q_data  = b_entry;

endmodule

`default_nettype wire

// ===== rtl/lpbe_queue.sv =====
`default_nettype none

module lpbe_queue
  import lpbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t in_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  output q_entry_t      out_data,
  output logic          out_valid,
  input  wire logic     out_ready
);

  q_entry_t   slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

  // count tracks the pointer distance
  assert property (@(posedge clk) disable iff (rst)
    (count != 2'd3) && ((count == 2'd1) == (wptr != rptr)))
    else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ===== rtl/lpbe_back.sv =====
`default_nettype none

module lpbe_back
  import lpbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire q_entry_t q_data,
  input  wire logic     q_valid,
  output logic          q_ready,
  lpbe_duty_if.source   res
);

  logic                    busy;
  cmd_e                    cur_cmd;
  logic [BitsPerPixel-1:0] cur_word;
  logic [CntWidth-1:0]     cnt;

  logic                    o_valid;
  logic [7:0]              o_duty;
  logic                    o_last;

  logic                    advance, take, beat_last;
  cmd_e                    src_cmd;
  logic [BitsPerPixel-1:0] src_word;
  logic [CntWidth-1:0]     src_cnt, gap_last, last_idx;
  logic [7:0]              beat_duty;

  always_comb begin
    if (cfg.reset_slots == '0) begin
      gap_last = '0;
    end else if (cfg.reset_slots > MaxGapSlots) begin
      gap_last = CntWidth'(MaxGapSlots - 7'd1);
    end else begin
      gap_last = CntWidth'(cfg.reset_slots - 7'd1);
    end
  end

  // start the next item in the same cycle the previous one ends
  assign src_cmd  = busy ? cur_cmd  : q_data.cmd;
  assign src_word = busy ? cur_word : q_data.word;
  assign src_cnt  = busy ? cnt      : '0;

  assign last_idx  = (src_cmd == CMD_LATCH) ? gap_last : PixelLastIdx;
  assign beat_last = (src_cnt == last_idx);
  assign beat_duty = (src_cmd == CMD_LATCH) ? 8'd0 :
                     (src_word[BitsPerPixel-1] ? cfg.duty_one : cfg.duty_zero);

  assign advance = !o_valid || res.ready;
  assign take    = advance && (busy || q_valid);
  assign q_ready = advance && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else if (take) begin
      busy    <= !beat_last;
      cnt     <= src_cnt + CntWidth'(1);
      o_valid <= 1'b1;
    end else if (advance) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_cmd  <= src_cmd;
      cur_word <= src_word << 1;
      o_duty   <= beat_duty;
      o_last   <= beat_last;
    end
  end

  assign res.valid = o_valid;
  assign res.duty  = o_duty;
  assign res.last  = o_last;

  assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("busy run with no beat sent");

  assert property (@(posedge clk) disable iff (rst)
    (take && beat_last) |=> (!busy && o_last && o_valid))
    else $error("run end not flagged");

  assert property (@(posedge clk) disable iff (rst)
    (busy && cur_cmd == CMD_PIXEL) |-> (cnt <= PixelLastIdx))
    else $error("pixel run overran its bits");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !advance) |=> (busy && $stable(cnt)))
    else $error("run advanced while output stalled");

endmodule

`default_nettype wire

// ===== rtl/led_pwm_bit_encoder.sv =====
`default_nettype none

// Channel  Modport  Payload                              Handshake
// pix      sink     cmd, red, green, blue, brightness    valid/ready
// res      source   duty, last                           valid/ready
// cfg      sink     index, data                          valid/ready (always ready)
//
// A pixel gives 24 results, a latch item 1 to 64; the result port sets the pace,
// one result per cycle, with no gap between runs of consecutive items.
// Intake passes two pipeline stages (multiply, scale by 1/100) and a two-entry
// queue, so up to four items are taken ahead of the one being sent.
// A stall on res holds the current result and fills the queue; pix.ready drops
// only when both stages and the queue are full.
// rst is synchronous; it empties the pipeline and queue and restores register defaults.

module led_pwm_bit_encoder
  import lpbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lpbe_pix_if.sink  pix,
  lpbe_duty_if.source res,
  lpbe_cfg_if.sink  cfg
);

  cfg_t     regs;
  q_entry_t f_data, b_data;
  logic     f_valid, f_ready, b_valid, b_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.duty_one    <= DutyOneReset;
      regs.duty_zero   <= DutyZeroReset;
      regs.reset_slots <= SlotsReset;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_DUTY_ONE:    regs.duty_one    <= cfg.data;
        REG_DUTY_ZERO:   regs.duty_zero   <= cfg.data;
        REG_RESET_SLOTS: regs.reset_slots <= cfg.data[SlotsWidth-1:0];
        default: ;
      endcase
    end
  end

  lpbe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .q_data  (f_data),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  lpbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_data),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (b_data),
    .out_valid (b_valid),
    .out_ready (b_ready)
  );

  lpbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_data  (b_data),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .res     (res)
  );

endmodule

`default_nettype wire
